>>> hw/rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// shared constants and types of the indexed min-heap queue
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_SPACE = 1024;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int ID_W     = $clog2(ID_SPACE);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POLL   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_CHK1,
        S_CHK2,
        S_ABS,
        S_POLL,
        S_RM0,
        S_RM1,
        S_RM2,
        S_INS,
        S_UP,
        S_UP2,
        S_DN,
        S_DN2,
        S_DN3,
        S_DN4,
        S_FIN
    } t_state;

endpackage

>>> hw/rtl/imhq_if.sv
// ----------------------------------------------------------------------------
// imhq channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface imhq_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [imhq_pkg::ID_W-1:0]     item_id;
    logic [imhq_pkg::KEY_BITS-1:0] prio_key;

    modport source (output valid, output cmd, output item_id, output prio_key, input ready);
    modport sink   (input valid, input cmd, input item_id, input prio_key, output ready);
endinterface

interface imhq_out_if;
    logic                          valid;
    logic                          ready;
    logic [imhq_pkg::ID_W-1:0]     out_id;
    logic [imhq_pkg::KEY_BITS-1:0] out_key;
    logic [1:0]                    status;
    logic [imhq_pkg::CNT_W-1:0]    fill_count;

    modport source (output valid, output out_id, output out_key, output status,
                    output fill_count, input ready);
    modport sink   (input valid, input out_id, input out_key, input status,
                    input fill_count, output ready);
endinterface

>>> hw/rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// binary min-heap of (id, key) pairs with an id-to-slot index
// ----------------------------------------------------------------------------
// One transaction is taken at a time and answered with one result. The heap
// lives in a ram of slots and the index in a ram of slot numbers, both with
// registered reads; presence of an id is proven by reading its index entry
// and checking that the slot is in use and holds that id. After reset the
// index ram is cleared in a pass over all 1024 entries during which no
// transaction is taken. Insert sifts up level by level; poll sifts down, and
// remove sifts the moved last item up or down, each level read through the
// single heap ram read port. A no-op or a poll of an empty heap goes straight
// to the result; a re-insert of a present id removes it, then inserts it.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    imhq_in_if.sink        i_in,
    imhq_out_if.source     o_out
);

    localparam int SW = imhq_pkg::SLOT_W;
    localparam int CW = imhq_pkg::CNT_W;
    localparam int IW = imhq_pkg::ID_W;
    localparam int KW = imhq_pkg::KEY_BITS;

    imhq_pkg::t_state  r_state, n_state;
    imhq_pkg::t_cmd    r_cmd, n_cmd;
    imhq_pkg::t_status r_st, n_st;
    logic [IW-1:0]     r_id, n_id, r_wid, n_wid, r_cid, n_cid, r_oid, n_oid;
    logic [KW-1:0]     r_key, n_key, r_wkey, n_wkey, r_ckey, n_ckey, r_okey, n_okey;
    logic [SW-1:0]     r_pos, n_pos, r_k, n_k, r_cidx, n_cidx;
    logic [CW-1:0]     r_size, n_size;
    logic              r_inserted, n_inserted;
    logic [IW-1:0]     r_clr, n_clr;

    logic              h_we, s_we;
    logic [SW-1:0]     h_waddr, h_raddr, s_wdata;
    logic [IW-1:0]     s_waddr, s_raddr;
    imhq_pkg::t_entry  h_wdata, h_rdata;
    logic [SW-1:0]     s_rdata;
    logic [SW-1:0]     w_par;
    logic [SW+1:0]     w_c, w_c1;
    logic              w_accept;

    imhq_ram #(.DEPTH(imhq_pkg::CAPACITY), .WIDTH(IW + KW)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    imhq_ram #(.DEPTH(imhq_pkg::ID_SPACE), .WIDTH(SW)) u_index (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign w_accept = i_in.valid && i_in.ready;
    assign w_par    = SW'((r_pos - SW'(1)) >> 1);
    assign w_c      = {1'b0, r_pos, 1'b1};
    assign w_c1     = w_c + (SW+2)'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imhq_pkg::S_CLR: begin
                n_state = (r_clr == '1) ? imhq_pkg::S_IDLE : imhq_pkg::S_CLR;
            end
            imhq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (imhq_pkg::t_cmd'(i_in.cmd))
                        imhq_pkg::CMD_INSERT, imhq_pkg::CMD_REMOVE: n_state = imhq_pkg::S_CHK1;
                        imhq_pkg::CMD_POLL: begin
                            n_state = (r_size == '0) ? imhq_pkg::S_FIN : imhq_pkg::S_POLL;
                        end
                        imhq_pkg::CMD_NOP: n_state = imhq_pkg::S_FIN;
                    endcase
                end
            end
            imhq_pkg::S_CHK1: begin
                n_state = ({1'b0, s_rdata} < r_size) ? imhq_pkg::S_CHK2 : imhq_pkg::S_ABS;
            end
            imhq_pkg::S_CHK2: begin
                n_state = (h_rdata.id == r_id) ? imhq_pkg::S_RM0 : imhq_pkg::S_ABS;
            end
            imhq_pkg::S_ABS: begin
                n_state = (r_cmd == imhq_pkg::CMD_INSERT) ? imhq_pkg::S_INS : imhq_pkg::S_FIN;
            end
            imhq_pkg::S_POLL: n_state = imhq_pkg::S_RM0;
            imhq_pkg::S_RM0:  n_state = imhq_pkg::S_RM1;
            imhq_pkg::S_RM1: begin
                n_state = ({1'b0, r_k} == r_size) ? imhq_pkg::S_FIN : imhq_pkg::S_RM2;
            end
            imhq_pkg::S_RM2: begin
                n_state = (r_wkey < h_rdata.key) ? imhq_pkg::S_UP : imhq_pkg::S_DN;
            end
            imhq_pkg::S_INS: begin
                n_state = (r_size >= CW'(imhq_pkg::CAPACITY)) ? imhq_pkg::S_FIN : imhq_pkg::S_UP;
            end
            imhq_pkg::S_UP: begin
                n_state = (r_pos == '0) ? imhq_pkg::S_FIN : imhq_pkg::S_UP2;
            end
            imhq_pkg::S_UP2: begin
                n_state = (r_wkey < h_rdata.key) ? imhq_pkg::S_UP : imhq_pkg::S_FIN;
            end
            imhq_pkg::S_DN: begin
                n_state = (w_c < {1'b0, r_size}) ? imhq_pkg::S_DN2 : imhq_pkg::S_FIN;
            end
            imhq_pkg::S_DN2: begin
                n_state = (w_c1 < {1'b0, r_size}) ? imhq_pkg::S_DN3 : imhq_pkg::S_DN4;
            end
            imhq_pkg::S_DN3: n_state = imhq_pkg::S_DN4;
            imhq_pkg::S_DN4: begin
                n_state = (r_ckey < r_wkey) ? imhq_pkg::S_DN : imhq_pkg::S_FIN;
            end
            imhq_pkg::S_FIN: begin
                if (r_cmd == imhq_pkg::CMD_INSERT && !r_inserted && r_st == imhq_pkg::ST_OK) begin
                    n_state = imhq_pkg::S_INS;
                end else if (o_out.ready) begin
                    n_state = imhq_pkg::S_IDLE;
                end
            end
            default: n_state = imhq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd      = r_cmd;
        n_st       = r_st;
        n_id       = r_id;
        n_key      = r_key;
        n_wid      = r_wid;
        n_wkey     = r_wkey;
        n_cid      = r_cid;
        n_ckey     = r_ckey;
        n_oid      = r_oid;
        n_okey     = r_okey;
        n_pos      = r_pos;
        n_k        = r_k;
        n_cidx     = r_cidx;
        n_size     = r_size;
        n_inserted = r_inserted;
        n_clr      = r_clr;
        h_we       = 1'b0;
        h_waddr    = r_pos;
        h_wdata    = '{id: r_wid, key: r_wkey};
        h_raddr    = '0;
        s_we       = 1'b0;
        s_waddr    = r_wid;
        s_wdata    = r_pos;
        s_raddr    = i_in.item_id;
        unique case (r_state)
            imhq_pkg::S_CLR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                s_wdata = '0;
                n_clr   = r_clr + IW'(1);
            end
            imhq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = imhq_pkg::t_cmd'(i_in.cmd);
                    n_id       = i_in.item_id;
                    n_key      = i_in.prio_key;
                    n_oid      = '0;
                    n_okey     = '0;
                    n_inserted = 1'b0;
                    n_st       = imhq_pkg::ST_OK;
                    if (imhq_pkg::t_cmd'(i_in.cmd) == imhq_pkg::CMD_POLL && r_size == '0) begin
                        n_st = imhq_pkg::ST_EMPTY;
                    end
                end
            end
            imhq_pkg::S_CHK1: begin
                n_k     = s_rdata;
                h_raddr = s_rdata;
            end
            imhq_pkg::S_ABS: begin
                if (r_cmd != imhq_pkg::CMD_INSERT) begin
                    n_st = imhq_pkg::ST_ABSENT;
                end
            end
            imhq_pkg::S_POLL: begin
                n_oid  = h_rdata.id;
                n_okey = h_rdata.key;
                n_k    = '0;
            end
            imhq_pkg::S_RM0: begin
                h_raddr = SW'(r_size - CW'(1));
                n_size  = r_size - CW'(1);
            end
            imhq_pkg::S_RM1: begin
                n_wid   = h_rdata.id;
                n_wkey  = h_rdata.key;
                h_raddr = r_k;
            end
            imhq_pkg::S_RM2: begin
                n_pos = r_k;
            end
            imhq_pkg::S_INS: begin
                if (r_size >= CW'(imhq_pkg::CAPACITY)) begin
                    n_st = imhq_pkg::ST_FULL;
                end else begin
                    n_pos      = SW'(r_size);
                    n_size     = r_size + CW'(1);
                    n_wid      = r_id;
                    n_wkey     = r_key;
                    n_inserted = 1'b1;
                end
            end
            imhq_pkg::S_UP: begin
                h_raddr = w_par;
                if (r_pos == '0) begin
                    h_we = 1'b1;
                    s_we = 1'b1;
                end
            end
            imhq_pkg::S_UP2: begin
                h_we = 1'b1;
                s_we = 1'b1;
                if (r_wkey < h_rdata.key) begin
                    h_wdata = h_rdata;
                    s_waddr = h_rdata.id;
                    n_pos   = w_par;
                end
            end
            imhq_pkg::S_DN: begin
                h_raddr = SW'(w_c);
                if (!(w_c < {1'b0, r_size})) begin
                    h_we = 1'b1;
                    s_we = 1'b1;
                end
            end
            imhq_pkg::S_DN2: begin
                n_cidx  = SW'(w_c);
                n_cid   = h_rdata.id;
                n_ckey  = h_rdata.key;
                h_raddr = SW'(w_c1);
            end
            imhq_pkg::S_DN3: begin
                if (h_rdata.key < r_ckey) begin
                    n_cidx = r_cidx + SW'(1);
                    n_cid  = h_rdata.id;
                    n_ckey = h_rdata.key;
                end
            end
            imhq_pkg::S_DN4: begin
                h_we = 1'b1;
                s_we = 1'b1;
                if (r_ckey < r_wkey) begin
                    h_wdata = '{id: r_cid, key: r_ckey};
                    s_waddr = r_cid;
                    n_pos   = r_cidx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= imhq_pkg::S_CLR;
            r_size     <= '0;
            r_inserted <= 1'b0;
            r_cmd      <= imhq_pkg::CMD_NOP;
            r_st       <= imhq_pkg::ST_OK;
            r_clr      <= '0;
        end else begin
            r_state    <= n_state;
            r_size     <= n_size;
            r_inserted <= n_inserted;
            r_cmd      <= n_cmd;
            r_st       <= n_st;
            r_clr      <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_key  <= n_key;
        r_wid  <= n_wid;
        r_wkey <= n_wkey;
        r_cid  <= n_cid;
        r_ckey <= n_ckey;
        r_oid  <= n_oid;
        r_okey <= n_okey;
        r_pos  <= n_pos;
        r_k    <= n_k;
        r_cidx <= n_cidx;
    end

    // outputs
    always_comb begin
        i_in.ready       = (r_state == imhq_pkg::S_IDLE);
        o_out.valid      = (r_state == imhq_pkg::S_FIN) &&
                           !(r_cmd == imhq_pkg::CMD_INSERT && !r_inserted &&
                             r_st == imhq_pkg::ST_OK);
        o_out.out_id     = r_oid;
        o_out.out_key    = r_okey;
        o_out.status     = r_st;
        o_out.fill_count = r_size;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("result pending while new transaction accepted");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CW'(imhq_pkg::CAPACITY))
        else $error("heap size beyond capacity");

    a_full_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == imhq_pkg::ST_FULL |->
        o_out.fill_count == CW'(imhq_pkg::CAPACITY))
        else $error("full status with free slots");

    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == imhq_pkg::ST_EMPTY |-> o_out.fill_count == '0)
        else $error("empty status with items held");

endmodule

>>> hw/rtl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module imhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
